[hw/rtl/lcmc_pkg.sv]
// Shared types, codes and constants for the lattice chain move checker.
// No dependencies; imported by lattice_chain_move_checker_top.
package lcmc_pkg;

  // Default sizes
  localparam int CHAIN_LENGTH_DEF = 128;
  localparam int BOX_SIZE_DEF     = 64;

  // Port field widths
  localparam int MONO_W = 8;
  localparam int MOVE_W = 5;
  localparam int CRD_W  = 7;
  localparam int STAT_W = 3;
  // Width wide enough to compare a port coordinate against the largest box
  localparam int CMP_W  = 9;

  localparam logic [MOVE_W-1:0] MOVE_LAST = 5'd26;

  typedef enum logic {
    REQ_PLACE = 1'b0,
    REQ_MOVE  = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_OCCUPIED  = 3'd2,
    ST_PREV_BOND = 3'd3,
    ST_NEXT_BOND = 3'd4,
    ST_PLACED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SELF,
    S_PREV,
    S_NEXT,
    S_PLACE_WR,
    S_CLR_OLD,
    S_FIN
  } state_t;

  // Base-3 digits of a move code; digit 0 means -1, 1 means 0, 2 means +1
  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
  } digits_t;

  function automatic digits_t move_digits(logic [MOVE_W-1:0] m);
    digits_t d;
    logic [MOVE_W-1:0] r;
    logic [MOVE_W-1:0] r2;
    if (m >= 5'd18) begin
      d.dx = 2'd2;
      r    = m - 5'd18;
    end else if (m >= 5'd9) begin
      d.dx = 2'd1;
      r    = m - 5'd9;
    end else begin
      d.dx = 2'd0;
      r    = m;
    end
    if (r >= 5'd6) begin
      d.dy = 2'd2;
      r2   = r - 5'd6;
    end else if (r >= 5'd3) begin
      d.dy = 2'd1;
      r2   = r - 5'd3;
    end else begin
      d.dy = 2'd0;
      r2   = r;
    end
    d.dz = r2[1:0];
    return d;
  endfunction

endpackage

[hw/rtl/lattice_chain_move_checker_top.sv]
// Lattice chain move checker: position memory, occupancy row memory and sequencer.
// Depends on lcmc_pkg.
//
// The block keeps CHAIN_LENGTH monomer positions in a one-port-read position memory and
// the occupancy of the BOX_SIZE^3 lattice in a row memory (one row of BOX_SIZE bits per
// (x,y) column). After reset a clearing pass zeroes one occupancy row per cycle, all
// 2^(2*clog2(BOX_SIZE)) rows (4096 at BOX_SIZE 64), while in_ready stays low. Each word
// is then handled alone: an invalid monomer index goes to S_FIN, a place runs S_SELF
// and, if inside the box, S_PLACE_WR, a rejected move ends after S_SELF, S_PREV or
// S_NEXT, and an accepted move runs S_SELF, S_PREV, S_NEXT and, if it leaves its
// column, S_CLR_OLD; S_FIN waits for a free output. With one read port per memory, the
// own, previous and next positions are read one per cycle, and an accepted move leaving
// its column needs a second occupancy row read-modify-write. The result sits in an
// output register, so a new word is taken while a result waits for out_ready.
module lattice_chain_move_checker_top
  import lcmc_pkg::*;
#(
  parameter int CHAIN_LENGTH = CHAIN_LENGTH_DEF,
  parameter int BOX_SIZE     = BOX_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [MONO_W-1:0] monomer_index,
  input  logic [MOVE_W-1:0] move_index,
  input  logic [CRD_W-1:0]  place_x,
  input  logic [CRD_W-1:0]  place_y,
  input  logic [CRD_W-1:0]  place_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [CRD_W-1:0]  pos_x,
  output logic [CRD_W-1:0]  pos_y,
  output logic [CRD_W-1:0]  pos_z
);

  localparam int IW   = $clog2(CHAIN_LENGTH);
  localparam int AW   = $clog2(BOX_SIZE);
  localparam int AW1  = AW + 1;
  localparam int RW   = 2 * AW;
  localparam int ROWS = 1 << RW;
  localparam int KW   = ((IW > MONO_W) ? IW : MONO_W) + 1;

  // Coordinates are held as coordinate minus one
  typedef struct packed {
    logic [AW-1:0] x;
    logic [AW-1:0] y;
    logic [AW-1:0] z;
  } coord_t;

  function automatic logic [CRD_W-1:0] to_port(logic [AW-1:0] c);
    logic [AW1-1:0] t;
    t = AW1'(c) + AW1'(1);
    return CRD_W'(t);
  endfunction

  function automatic logic adj(logic [AW-1:0] p, logic [AW-1:0] q);
    return (AW1'(p) + AW1'(1) == AW1'(q)) || (AW1'(q) + AW1'(1) == AW1'(p));
  endfunction

  // Squared distance one: exactly one axis off by one, the others equal
  function automatic logic unit_bond(coord_t a, coord_t b);
    return (adj(a.x, b.x) && a.y == b.y && a.z == b.z) ||
           (a.x == b.x && adj(a.y, b.y) && a.z == b.z) ||
           (a.x == b.x && a.y == b.y && adj(a.z, b.z));
  endfunction

  function automatic logic [RW-1:0] row_of(coord_t c);
    return {c.x, c.y};
  endfunction

  function automatic logic [BOX_SIZE-1:0] bit_of(coord_t c);
    return BOX_SIZE'(1) << c.z;
  endfunction

  // Memories
  coord_t              pos_mem [CHAIN_LENGTH];
  logic [BOX_SIZE-1:0] occ_mem [ROWS];

  state_t              state, state_next;
  logic [RW-1:0]       clr_cnt;

  // Word registers
  req_t                req_r;
  logic [IW-1:0]       idx_r;
  logic                has_prev_r, has_next_r, mv_ok_r, place_ok_r;
  digits_t             dig_r;
  coord_t              plc_r, own_r, new_r;
  logic [BOX_SIZE-1:0] row_buf;
  status_t             res_status;
  logic [CRD_W-1:0]    res_x, res_y, res_z;

  // Memory ports
  logic [IW-1:0]       pos_raddr;
  coord_t              pos_q;
  logic                pos_we;
  coord_t              pos_wdata;
  logic [RW-1:0]       occ_raddr, occ_waddr;
  logic [BOX_SIZE-1:0] occ_q, occ_wdata;
  logic                occ_we;

  // Decode of the incoming word
  logic                in_fire, out_free;
  logic [KW-1:0]       k_ext, km1;
  logic                kvalid_in;
  coord_t              plc_in;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign k_ext     = KW'(monomer_index);
  assign km1       = k_ext - KW'(1);
  assign kvalid_in = (k_ext != '0) && (k_ext <= KW'(CHAIN_LENGTH));
  assign plc_in.x  = AW'(place_x - CRD_W'(1));
  assign plc_in.y  = AW'(place_y - CRD_W'(1));
  assign plc_in.z  = AW'(place_z - CRD_W'(1));

  // Move target from the own position read in S_SELF
  coord_t new_c;
  logic   new_in_box;
  logic   occ_hit, prev_bad, next_bad, same_row;

  assign new_c.x = pos_q.x + AW'(dig_r.dx) - AW'(1);
  assign new_c.y = pos_q.y + AW'(dig_r.dy) - AW'(1);
  assign new_c.z = pos_q.z + AW'(dig_r.dz) - AW'(1);
  assign new_in_box =
    !((pos_q.x == '0 && dig_r.dx == 2'd0) || (pos_q.x == AW'(BOX_SIZE - 1) && dig_r.dx == 2'd2) ||
      (pos_q.y == '0 && dig_r.dy == 2'd0) || (pos_q.y == AW'(BOX_SIZE - 1) && dig_r.dy == 2'd2) ||
      (pos_q.z == '0 && dig_r.dz == 2'd0) || (pos_q.z == AW'(BOX_SIZE - 1) && dig_r.dz == 2'd2));

  // Checks against the neighbor read in S_PREV / S_NEXT
  assign occ_hit  = occ_q[new_r.z];
  assign prev_bad = has_prev_r && !unit_bond(new_r, pos_q);
  assign next_bad = has_next_r && !unit_bond(new_r, pos_q);
  assign same_row = (row_of(new_r) == row_of(own_r));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (&clr_cnt) state_next = S_IDLE;
      S_IDLE:     if (in_fire) state_next = kvalid_in ? S_SELF : S_FIN;
      S_SELF: begin
        if (req_r == REQ_PLACE) begin
          state_next = place_ok_r ? S_PLACE_WR : S_FIN;
        end else begin
          state_next = (mv_ok_r && new_in_box) ? S_PREV : S_FIN;
        end
      end
      S_PREV:     state_next = (occ_hit || prev_bad) ? S_FIN : S_NEXT;
      S_NEXT:     state_next = (next_bad || same_row) ? S_FIN : S_CLR_OLD;
      S_CLR_OLD:  state_next = S_FIN;
      S_PLACE_WR: state_next = S_FIN;
      S_FIN:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    pos_raddr = idx_r;
    pos_we    = 1'b0;
    pos_wdata = new_r;
    occ_raddr = row_of(new_c);
    occ_we    = 1'b0;
    occ_waddr = row_of(new_r);
    occ_wdata = row_buf | bit_of(new_r);
    unique case (state)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_cnt;
        occ_wdata = '0;
      end
      S_IDLE:   pos_raddr = km1[IW-1:0];
      S_SELF: begin
        pos_raddr = idx_r - IW'(1);
        occ_raddr = (req_r == REQ_PLACE) ? row_of(plc_r) : row_of(new_c);
      end
      S_PREV:   pos_raddr = idx_r + IW'(1);
      S_NEXT: begin
        occ_raddr = row_of(own_r);
        if (!next_bad) begin
          pos_we = 1'b1;
          occ_we = 1'b1;
          // set the new cell; clear the old one too when both share a row
          if (same_row) occ_wdata = (row_buf | bit_of(new_r)) & ~bit_of(own_r);
        end
      end
      S_CLR_OLD: begin
        occ_we    = 1'b1;
        occ_waddr = row_of(own_r);
        occ_wdata = occ_q & ~bit_of(own_r);
      end
      S_PLACE_WR: begin
        pos_we    = 1'b1;
        pos_wdata = plc_r;
        occ_we    = 1'b1;
        occ_waddr = row_of(plc_r);
        occ_wdata = occ_q | bit_of(plc_r);
      end
      S_FIN:    pos_raddr = idx_r;
      default:  pos_raddr = idx_r;
    endcase
  end

  // Position memory
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[idx_r] <= pos_wdata;
    pos_q <= pos_mem[pos_raddr];
  end

  // Occupancy row memory
  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    occ_q <= occ_mem[occ_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + RW'(1);
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Word datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          req_r      <= req_t'(req_type);
          idx_r      <= km1[IW-1:0];
          has_prev_r <= (k_ext > KW'(1));
          has_next_r <= (k_ext < KW'(CHAIN_LENGTH));
          mv_ok_r    <= (move_index <= MOVE_LAST);
          dig_r      <= move_digits(move_index);
          plc_r      <= plc_in;
          place_ok_r <= (place_x != '0) && (place_y != '0) && (place_z != '0) &&
                        (CMP_W'(place_x) <= CMP_W'(BOX_SIZE)) &&
                        (CMP_W'(place_y) <= CMP_W'(BOX_SIZE)) &&
                        (CMP_W'(place_z) <= CMP_W'(BOX_SIZE));
          // invalid index reports zeros
          res_status <= ST_OUTSIDE;
          res_x      <= '0;
          res_y      <= '0;
          res_z      <= '0;
        end
      end
      S_SELF: begin
        own_r      <= pos_q;
        new_r      <= new_c;
        res_status <= ST_OUTSIDE;
        res_x      <= to_port(pos_q.x);
        res_y      <= to_port(pos_q.y);
        res_z      <= to_port(pos_q.z);
      end
      S_PREV: begin
        row_buf    <= occ_q;
        res_status <= occ_hit ? ST_OCCUPIED : ST_PREV_BOND;
      end
      S_NEXT: begin
        if (next_bad) begin
          res_status <= ST_NEXT_BOND;
        end else begin
          res_status <= ST_ACCEPTED;
          res_x      <= to_port(new_r.x);
          res_y      <= to_port(new_r.y);
          res_z      <= to_port(new_r.z);
        end
      end
      S_PLACE_WR: begin
        res_status <= ST_PLACED;
        res_x      <= to_port(plc_r.x);
        res_y      <= to_port(plc_r.y);
        res_z      <= to_port(plc_r.z);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      status <= res_status;
      pos_x  <= res_x;
      pos_y  <= res_y;
      pos_z  <= res_z;
    end
  end

`ifndef SYNTHESIS
  // A new result only comes out of the final state
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result loaded outside S_FIN");

  // Clearing pass hands over to idle after its last row
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && (&clr_cnt)) |=> state == S_IDLE)
    else $error("clearing pass did not end");

  // Committing a real displacement always marks its target cell
  a_move_sets_cell: assert property (@(posedge clk) disable iff (rst)
    (state == S_NEXT && occ_we && new_r != own_r) |-> occ_wdata[new_r.z] && pos_we)
    else $error("accepted move lost its target cell");

  // Placing marks the placed cell and writes the position
  a_place_sets_cell: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE_WR) |-> occ_we && pos_we && occ_wdata[plc_r.z])
    else $error("place did not mark its cell");
`endif

endmodule
